// ===== sv/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions of the SHA-1 byte-stream hasher.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SCHED_DEPTH = 16;
  localparam int unsigned DIGEST_WDS  = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [DIGEST_WDS-1:0][WORD_W-1:0] digest_t;

  // commands carried by an input item
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [3:0] LEN_WORD_HI   = 4'd14;
  localparam logic [3:0] LEN_WORD_LO   = 4'd15;
  localparam logic [6:0] SCHED_ROUNDS  = 7'd16;
  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam digest_t INIT_VECTOR = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  // round function by round group
  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  // additive constant by round group
  function automatic word_t round_k(input logic [6:0] rnd);
    word_t res;
    if (rnd < 7'd20) begin
      res = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      res = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      res = 32'h8F1BBCDC;
    end else begin
      res = 32'hCA62C1D6;
    end
    return res;
  endfunction

endpackage

// ===== sv/sha1md_ram.sv =====
// ----------------------------------------------------------------------------
// sha1md_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module sha1md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== sv/sha1md_emit.sv =====
// ----------------------------------------------------------------------------
// sha1md_emit
// Digest output buffer: holds the five words and hands them out in order.
// ----------------------------------------------------------------------------
module sha1md_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sha1md_pkg::digest_t  words_in,
  output logic                 busy,
  output logic                 dig_valid,
  input  logic                 dig_stall,
  output sha1md_pkg::dig_t     dig
);

  sha1md_pkg::digest_t words;
  logic [2:0]          idx;
  logic                valid;
  logic                take;

  assign take      = valid && !dig_stall;
  assign busy      = valid;
  assign dig_valid = valid;

  // head word goes out
  assign dig.digest_word = words[0];
  assign dig.word_index  = idx;
  assign dig.last_word   = (idx == sha1md_pkg::LAST_WORD_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
      words <= words_in;
    end else if (take) begin
      // shift the next word to the head
      for (int i = 0; i < 4; i++) begin
        words[i] <= words[i+1];
      end
      idx <= idx + 3'd1;
      if (idx == sha1md_pkg::LAST_WORD_IDX) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1 hasher, one message byte per input item.
// ----------------------------------------------------------------------------
// Input channel msg (msg_valid / msg_stall): command append carries one byte,
// command finish pads the message and produces the digest.
// Output channel dig (dig_valid / dig_stall): five 32-bit digest words,
// word_index 0 to 4, last_word set on the fifth.
// The 64th byte of a block starts the compression: the schedule memory is
// primed, 80 rounds run at one per cycle, then the result is folded into the
// chaining value; the input stalls throughout.
// A finish writes the padding words one per cycle (up to 16), compresses, and
// when fewer than 9 bytes were free, pads and compresses a second block. The
// digest then moves into an output buffer and the hasher returns to the
// initial vector, taking items again while the words drain.
// The round count of the single shared round unit sets the rate.
// A stalled receiver holds the output buffer; a further digest waits, with the
// input stalled, until the buffer is empty. Reset clears the fill and block
// counts, loads the initial vector and empties the output buffer.
// ----------------------------------------------------------------------------
module sha1_message_digest (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  sha1md_pkg::msg_t  msg,
  output logic              dig_valid,
  input  logic              dig_stall,
  output sha1md_pkg::dig_t  dig
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_PRIME, S_ROUND, S_FOLD, S_FINAL
  } state_t;

  localparam int unsigned AW = $clog2(sha1md_pkg::SCHED_DEPTH);

  state_t               state;
  logic [5:0]           fill;
  logic [23:0]          pack;
  logic [54:0]          blk_cnt;
  sha1md_pkg::digest_t  chain;
  sha1md_pkg::word_t    va, vb, vc, vd, ve;
  logic [6:0]           rnd;
  logic [3:0]           widx;
  logic                 fin;
  logic                 extra;
  logic                 second;
  logic [63:0]          len_bits;

  logic                 accept;
  logic [AW-1:0]        rd_base;
  logic [AW-1:0]        ra0, ra1, rb0, rb1;
  sha1md_pkg::word_t    rda0, rda1, rdb0, rdb1;
  sha1md_pkg::word_t    w_mix, w_exp, w_cur, t_sum;
  sha1md_pkg::word_t    mark_word, pad_word;
  logic                 we;
  logic [AW-1:0]        waddr;
  sha1md_pkg::word_t    wdata;
  logic                 emit_busy;
  logic                 emit_load;

  assign msg_stall = (state != S_IDLE);
  assign accept    = msg_valid && (state == S_IDLE);
  assign emit_load = (state == S_FINAL) && !emit_busy;

  // schedule reads are issued one round ahead
  assign rd_base = (state == S_PRIME) ? '0 : (rnd[AW-1:0] + AW'(1));
  assign ra0 = rd_base;
  assign ra1 = rd_base + AW'(2);
  assign rb0 = rd_base + AW'(8);
  assign rb1 = rd_base + AW'(13);

  // message expansion and round sum
  assign w_mix = rda0 ^ rda1 ^ rdb0 ^ rdb1;
  assign w_exp = {w_mix[30:0], w_mix[31]};
  assign w_cur = (rnd < sha1md_pkg::SCHED_ROUNDS) ? rda0 : w_exp;
  assign t_sum = {va[26:0], va[31:27]} + sha1md_pkg::round_f(rnd, vb, vc, vd)
               + ve + sha1md_pkg::round_k(rnd) + w_cur;

  // word holding the last partial bytes and the pad marker
  always_comb begin
    case (fill[1:0])
      2'd0:    mark_word = {sha1md_pkg::PAD_MARK, 24'h000000};
      2'd1:    mark_word = {pack[7:0], sha1md_pkg::PAD_MARK, 16'h0000};
      2'd2:    mark_word = {pack[15:0], sha1md_pkg::PAD_MARK, 8'h00};
      2'd3:    mark_word = {pack[23:0], sha1md_pkg::PAD_MARK};
      default: mark_word = '0;
    endcase
  end

  // padding word for the current slot
  always_comb begin
    pad_word = '0;
    if (!second && (widx == fill[5:2])) begin
      pad_word = mark_word;
    end else if (second || !extra) begin
      if (widx == sha1md_pkg::LEN_WORD_HI) begin
        pad_word = len_bits[63:32];
      end else if (widx == sha1md_pkg::LEN_WORD_LO) begin
        pad_word = len_bits[31:0];
      end
    end
  end

  // schedule memory write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (accept && (msg.command == sha1md_pkg::CMD_APPEND) && (fill[1:0] == 2'd3)) begin
      we    = 1'b1;
      waddr = fill[5:2];
      wdata = {pack, msg.data_byte};
    end else if (state == S_PAD) begin
      we    = 1'b1;
      waddr = widx;
      wdata = pad_word;
    end else if ((state == S_ROUND) && (rnd >= sha1md_pkg::SCHED_ROUNDS)) begin
      we    = 1'b1;
      waddr = rnd[AW-1:0];
      wdata = w_exp;
    end
  end

  // two copies of the schedule window give four reads per round
  sha1md_ram #(
    .WIDTH (sha1md_pkg::WORD_W),
    .DEPTH (sha1md_pkg::SCHED_DEPTH)
  ) u_sched_a (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rda0),
    .rdata1 (rda1)
  );

  sha1md_ram #(
    .WIDTH (sha1md_pkg::WORD_W),
    .DEPTH (sha1md_pkg::SCHED_DEPTH)
  ) u_sched_b (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (rb0),
    .raddr1 (rb1),
    .rdata0 (rdb0),
    .rdata1 (rdb1)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      blk_cnt <= '0;
      chain   <= sha1md_pkg::INIT_VECTOR;
      fin     <= 1'b0;
      second  <= 1'b0;
      rnd     <= '0;
      widx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg.command == sha1md_pkg::CMD_APPEND) begin
              pack <= {pack[15:0], msg.data_byte};
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                fin   <= 1'b0;
                state <= S_PRIME;
              end
            end else begin
              fin      <= 1'b1;
              second   <= 1'b0;
              extra    <= (fill[5:3] == 3'b111);
              len_bits <= {blk_cnt, fill, 3'b000};
              widx     <= fill[5:2];
              state    <= S_PAD;
            end
          end
        end
        S_PAD: begin
          widx <= widx + 4'd1;
          if (widx == sha1md_pkg::LEN_WORD_LO) begin
            state <= S_PRIME;
          end
        end
        S_PRIME: begin
          va    <= chain[0];
          vb    <= chain[1];
          vc    <= chain[2];
          vd    <= chain[3];
          ve    <= chain[4];
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          va  <= t_sum;
          vb  <= va;
          vc  <= {vb[1:0], vb[31:2]};
          vd  <= vc;
          ve  <= vd;
          rnd <= rnd + 7'd1;
          if (rnd == sha1md_pkg::LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          blk_cnt  <= blk_cnt + 55'd1;
          if (!fin) begin
            state <= S_IDLE;
          end else if (extra && !second) begin
            second <= 1'b1;
            widx   <= '0;
            state  <= S_PAD;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (!emit_busy) begin
            chain   <= sha1md_pkg::INIT_VECTOR;
            blk_cnt <= '0;
            fill    <= '0;
            fin     <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha1md_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .words_in  (chain),
    .busy      (emit_busy),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

endmodule

// ===== sv/sha1md_chk.sv =====
// ----------------------------------------------------------------------------
// sha1md_chk
// Port-level checks of the digest output sequence and of reset, bound to the top level.
// ----------------------------------------------------------------------------
module sha1md_chk (
  input logic              clk,
  input logic              rst,
  input logic              msg_stall,
  input logic              dig_valid,
  input logic              dig_stall,
  input sha1md_pkg::dig_t  dig
);

  // a stalled word holds
  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(dig))
    else $error("digest item changed under stall");

  // last flag marks word four only
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig.last_word == (dig.word_index == sha1md_pkg::LAST_WORD_IDX)))
    else $error("last_word does not match word_index");

  // words follow one another without a gap
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !dig.last_word |=>
      dig_valid && (dig.word_index == ($past(dig.word_index) + 3'd1)))
    else $error("digest word sequence broken");

  // a digest starts at word zero
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> (dig.word_index == 3'd0))
    else $error("digest did not start at word zero");

  // reset empties the output and opens the input
  a_reset_out: assert property (@(posedge clk)
    rst |=> !dig_valid && !msg_stall)
    else $error("output valid or input stalled after reset");

endmodule

bind sha1_message_digest sha1md_chk u_sha1md_chk (
  .clk       (clk),
  .rst       (rst),
  .msg_stall (msg_stall),
  .dig_valid (dig_valid),
  .dig_stall (dig_stall),
  .dig       (dig)
);

// ===== tb/sha1_message_digest_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_tb
// Streams byte messages through the SHA-1 hasher and checks every digest word
// against a behavioral SHA-1 kept in the bench. Message lengths cluster around
// the block and padding boundaries. The sender idles in bursts, and the
// receiver stalls on its own pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module sha1_message_digest_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 450;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE_WAIT  = 300;

  typedef struct {
    sha1md_pkg::msg_t item;
    bit               drain_first;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  sha1md_pkg::msg_t msg = '0;
  logic dig_valid;
  logic dig_stall = 1'b0;
  sha1md_pkg::dig_t dig;

  stream_item_t     stream_plan[$];
  sha1md_pkg::dig_t digest_q[$];

  int items_planned;
  int items_accepted;
  int messages_planned;
  int words_seen;
  int mismatches;
  int cycle_count;

  // bench-side hash state
  logic [7:0]        msg_bytes [64];
  int                bytes_held;
  logic [54:0]       blocks_done;
  sha1md_pkg::word_t hash_state [5];

  sha1_message_digest dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // return the bench hash to the initial vector
  task automatic restart_hash();
    bytes_held  = 0;
    blocks_done = '0;
    hash_state[0] = 32'h67452301;
    hash_state[1] = 32'hEFCDAB89;
    hash_state[2] = 32'h98BADCFE;
    hash_state[3] = 32'h10325476;
    hash_state[4] = 32'hC3D2E1F0;
  endtask

  // 80-round compression of msg_bytes into hash_state
  task automatic fold_block();
    sha1md_pkg::word_t sched [16];
    sha1md_pkg::word_t a, b, c, d, e, f, k, t, w;
    int r;
    for (r = 0; r < 16; r++) begin
      sched[r] = {msg_bytes[4*r], msg_bytes[4*r+1], msg_bytes[4*r+2], msg_bytes[4*r+3]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16];
        w = {w[30:0], w[31]};
        sched[r%16] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    blocks_done++;
  endtask

  // advance the bench hash by one accepted item, queue digest words on finish
  task automatic hash_item(input sha1md_pkg::msg_t it);
    logic [63:0]      bit_len;
    sha1md_pkg::dig_t word;
    int               i;
    if (it.command == sha1md_pkg::CMD_APPEND) begin
      msg_bytes[bytes_held] = it.data_byte;
      bytes_held++;
      if (bytes_held == 64) begin
        fold_block();
        bytes_held = 0;
      end
    end else begin
      bit_len = {blocks_done, 6'(bytes_held), 3'b000};
      msg_bytes[bytes_held] = sha1md_pkg::PAD_MARK;
      for (i = bytes_held + 1; i < 64; i++) msg_bytes[i] = 8'h00;
      // no room for the length: spill into an extra block
      if (bytes_held >= 56) begin
        fold_block();
        for (i = 0; i < 64; i++) msg_bytes[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) msg_bytes[56+i] = bit_len[63-8*i -: 8];
      fold_block();
      for (i = 0; i < 5; i++) begin
        word.digest_word = hash_state[i];
        word.word_index  = 3'(i);
        word.last_word   = (3'(i) == sha1md_pkg::LAST_WORD_IDX);
        digest_q.push_back(word);
      end
      restart_hash();
    end
  endtask

  // queue one message: bytes then a finish with a junk data byte
  task automatic plan_message(input int len, input bit drain_first);
    stream_item_t s;
    int i;
    for (i = 0; i <= len; i++) begin
      s.drain_first     = drain_first && (i == 0);
      s.item.command    = (i == len) ? sha1md_pkg::CMD_FINISH : sha1md_pkg::CMD_APPEND;
      s.item.data_byte  = 8'($urandom_range(0, 255));
      stream_plan.push_back(s);
    end
    items_planned += len + 1;
    messages_planned++;
  endtask

  // queue a message with fixed bytes
  task automatic plan_bytes(input logic [7:0] bytes[$]);
    stream_item_t s;
    s.drain_first = 1'b0;
    foreach (bytes[i]) begin
      s.item.command   = sha1md_pkg::CMD_APPEND;
      s.item.data_byte = bytes[i];
      stream_plan.push_back(s);
    end
    s.item.command   = sha1md_pkg::CMD_FINISH;
    s.item.data_byte = 8'hFF;
    stream_plan.push_back(s);
    items_planned += bytes.size() + 1;
    messages_planned++;
  endtask

  // driver: bursts of items with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      msg_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      restart_hash();
    end else begin
      if (msg_valid && !msg_stall) begin
        hash_item(msg);
        items_accepted++;
      end
      if (!msg_valid || !msg_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          msg_valid <= 1'b0;
        end else if (stream_plan.size() > 0 &&
                     !(stream_plan[0].drain_first && digest_q.size() > 0)) begin
          msg       <= stream_plan[0].item;
          msg_valid <= 1'b1;
          stream_plan.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          msg_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: randomly chosen stall pattern, one long hold-off
  int  rx_cycle;
  int  hold_left;
  int  stall_mode;
  bit  long_hold_done;

  always @(posedge clk) begin
    if (rst) begin
      dig_stall      <= 1'b0;
      rx_cycle       = 0;
      hold_left      = 0;
      stall_mode     = 0;
      long_hold_done = 1'b0;
    end else begin
      rx_cycle++;
      if (!long_hold_done && words_seen >= 10) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        dig_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: dig_stall <= 1'b0;
          1: dig_stall <= 1'($urandom_range(0, 1));
          default: dig_stall <= (rx_cycle % 4 != 0);
        endcase
      end
    end
  end

  task automatic report_mismatch(input string why, input sha1md_pkg::dig_t want,
                                 input sha1md_pkg::dig_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at cycle %0d", why, cycle_count);
      $display("  expected word %h idx %0d last %0b, got word %h idx %0d last %0b",
               want.digest_word, want.word_index, want.last_word,
               got.digest_word, got.word_index, got.last_word);
    end
  endtask

  // monitor: compare each accepted digest word with the oldest expectation
  always @(posedge clk) begin
    sha1md_pkg::dig_t want;
    if (!rst && dig_valid && !dig_stall) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected", '0, dig);
      end else begin
        want = digest_q.pop_front();
        if (dig.digest_word !== want.digest_word || dig.word_index !== want.word_index ||
            dig.last_word !== want.last_word) begin
          report_mismatch("value", want, dig);
        end
      end
    end
  end

  // timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sha1_message_digest regression: fail");
    $finish;
  end

  // stimulus plan and end of run
  initial begin
    int boundary_lens[11] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int sel;
    int len;

    // directed: empty message, known text, byte extremes, back-to-back finish
    plan_message(0, 1'b0);
    plan_bytes('{8'h61, 8'h62, 8'h63});
    plan_bytes('{8'h00, 8'hFF});
    plan_message(0, 1'b0);
    plan_bytes('{8'h80, 8'h7F, 8'h01, 8'hFE});

    // random messages, lengths weighted toward short messages and the padding boundaries
    plan_message(56, 1'b1);
    while (items_planned < TARGET_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) len = $urandom_range(0, 12);
      else if (sel < 8) len = boundary_lens[$urandom_range(0, 10)];
      else len = $urandom_range(0, 140);
      plan_message(len, $urandom_range(0, 5) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_planned) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("covered %0d items in %0d messages, %0d digest words checked",
             items_accepted, messages_planned, words_seen);
    $display("incl. empty messages, block-boundary lengths and a long receiver hold-off");
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("sha1_message_digest regression: pass");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, digest_q.size());
      $display("sha1_message_digest regression: fail");
    end
    $finish;
  end

endmodule
